// ===== hdl/sparse_depth_median_filter_defines.svh =====
// Assertion macros for the sparse depth median filter.
`ifndef SPARSE_DEPTH_MEDIAN_FILTER_DEFINES_SVH
`define SPARSE_DEPTH_MEDIAN_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define SDMF_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sdmf check failed");
`define SDMF_CHECK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sdmf check failed");
`else
`define SDMF_CHECK(label, clk, rst_n, prop)
`define SDMF_CHECK_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hdl/sdmf_pkg.sv =====
`default_nettype none
package sdmf_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_ROWS   = 2'd0;
    localparam logic [1:0] CFG_COLS   = 2'd1;
    localparam logic [1:0] CFG_KERNEL = 2'd2;

    localparam logic [9:0] ROWS_RESET   = 10'd512;
    localparam logic [9:0] COLS_RESET   = 10'd512;
    localparam logic [3:0] KERNEL_RESET = 4'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [8:0]  pixel_row;
        logic [8:0]  pixel_col;
        logic [15:0] depth_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] filtered_depth;
        logic [8:0]  out_row;
        logic [8:0]  out_col;
        logic        coord_error;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        logic [9:0] value;
    } t_cfg_item;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_BYP_RD,
        ST_BYP_TAKE,
        ST_SCAN,
        ST_DRAIN,
        ST_STEP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic sweep_init;
        logic sweep_step;
        logic decode;
        logic write;
        logic byp_rd;
        logic byp_take;
        logic scan_step;
        logic pass_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       sweep_last;
        logic       in_frame;
        logic       kzero;
        logic       scan_last;
        logic       sel_done;
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== hdl/sdmf_if.sv =====
`default_nettype none
interface sdmf_in_if import sdmf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdmf_out_if import sdmf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdmf_cfg_if import sdmf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/sdmf_ram.sv =====
`default_nettype none
module sdmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/sdmf_ctrl.sv =====
`default_nettype none
module sdmf_ctrl import sdmf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_st,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP:    if (i_st.sweep_last) n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_DECODE;
            ST_DECODE: begin
                case (i_st.op)
                    OP_CLEAR: n_state = ST_SWEEP;
                    OP_WRITE: n_state = ST_WRITE;
                    OP_READ: begin
                        if (!i_st.in_frame)   n_state = ST_EMIT;
                        else if (i_st.kzero)  n_state = ST_BYP_RD;
                        else                  n_state = ST_SCAN;
                    end
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_WRITE:    n_state = ST_IDLE;
            ST_BYP_RD:   n_state = ST_BYP_TAKE;
            ST_BYP_TAKE: n_state = ST_EMIT;
            ST_SCAN:     if (i_st.scan_last) n_state = ST_DRAIN;
            ST_DRAIN:    n_state = ST_STEP;
            ST_STEP:     n_state = i_st.sel_done ? ST_EMIT : ST_SCAN;
            ST_EMIT:     if (i_st.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_SWEEP:    o_cmd.sweep_step = 1'b1;
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.decode     = 1'b1;
                o_cmd.sweep_init = (i_st.op == OP_CLEAR);
            end
            ST_WRITE:    o_cmd.write = 1'b1;
            ST_BYP_RD:   o_cmd.byp_rd = 1'b1;
            ST_BYP_TAKE: o_cmd.byp_take = 1'b1;
            ST_SCAN:     o_cmd.scan_step = 1'b1;
            ST_STEP:     o_cmd.pass_step = 1'b1;
            ST_EMIT:     o_cmd.emit = i_st.out_free;
            default:     o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/sdmf_datapath.sv =====
`default_nettype none
module sdmf_datapath import sdmf_pkg::*; #(
    parameter int MAX_ROWS   = 512,
    parameter int MAX_COLS   = 512,
    parameter int MAX_KERNEL = 15,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    output t_status        o_st,
    input  wire t_in_item  i_item,
    input  wire logic      i_cfg_we,
    input  wire t_cfg_item i_cfg,
    input  wire logic      i_out_ready,
    output logic           o_out_valid,
    output t_out_item      o_out
);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW0   = $clog2(MAX_ROWS + 1);
    localparam int CW0   = $clog2(MAX_COLS + 1);
    localparam int CW1   = (RW0 > CW0) ? RW0 : CW0;
    localparam int CW    = (CW1 > 10) ? CW1 : 10;
    localparam int KW0   = $clog2(MAX_KERNEL + 1);
    localparam int KW    = (KW0 > 4) ? KW0 : 4;
    localparam int WS    = 2 * ((MAX_KERNEL + 1) / 2);
    localparam int NW    = $clog2(WS * WS + 1);
    localparam int LW    = AW + CW;

    logic [9:0]  r_rows, r_cols;
    logic [3:0]  r_kern;
    t_in_item    r_item;
    logic        r_inside;

    logic [CW-1:0] r_top, r_btm, r_lft, r_rgt, r_y, r_x;
    logic [AW-1:0] r_clr;
    logic          r_rd_vld;
    logic [NW-1:0] r_cnt, r_k;
    logic          r_cntpass;
    logic [DEPTH_BITS-1:0] r_prefix, r_hmask, r_bsel, r_val;
    logic          r_out_vld;

    logic [CW-1:0] rows_sat, cols_sat, row_e, col_e, hc;
    logic [CW-1:0] top_c, btm_c, lft_c, rgt_c;
    logic [KW-1:0] kern_e, ksat;
    logic          inside_c, hit, take_one;
    logic [LW-1:0] lin_item, lin_scan;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [DEPTH_BITS-1:0] ram_wdata, ram_rdata, prefix_nx;

    always_comb begin
        rows_sat = (CW'(r_rows) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(r_rows);
        cols_sat = (CW'(r_cols) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(r_cols);
        row_e    = CW'(r_item.pixel_row);
        col_e    = CW'(r_item.pixel_col);
        kern_e   = KW'(r_kern);
        ksat     = (kern_e > KW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : kern_e;
        hc       = (CW'(ksat) + CW'(1)) >> 1;
        inside_c = (row_e < rows_sat) && (col_e < cols_sat);
        top_c    = (row_e >= hc) ? row_e - hc : '0;
        lft_c    = (col_e >= hc) ? col_e - hc : '0;
        btm_c    = (row_e + hc > rows_sat) ? rows_sat : row_e + hc;
        rgt_c    = (col_e + hc > cols_sat) ? cols_sat : col_e + hc;
        lin_item = LW'(row_e) * LW'(MAX_COLS) + LW'(col_e);
        lin_scan = LW'(r_y) * LW'(MAX_COLS) + LW'(r_x);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        ram_addr  = lin_scan[AW-1:0];
        if (i_cmd.sweep_step) begin
            ram_we   = 1'b1;
            ram_addr = r_clr;
        end else if (i_cmd.write) begin
            ram_we    = r_inside;
            ram_wdata = DEPTH_BITS'(r_item.depth_in);
            ram_addr  = lin_item[AW-1:0];
        end else if (i_cmd.byp_rd) begin
            ram_addr = lin_item[AW-1:0];
        end
    end

    sdmf_ram #(.WIDTH(DEPTH_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_cntpass) begin
            hit = (ram_rdata != '0);
        end else begin
            hit = (ram_rdata != '0) && (((ram_rdata ^ r_prefix) & r_hmask) == '0)
                  && ((ram_rdata & r_bsel) == '0);
        end
        take_one  = (r_k >= r_cnt);
        prefix_nx = take_one ? (r_prefix | r_bsel) : r_prefix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= ROWS_RESET;
            r_cols      <= COLS_RESET;
            r_kern      <= KERNEL_RESET;
            r_clr       <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg.index)
                    CFG_ROWS:   r_rows <= i_cfg.value;
                    CFG_COLS:   r_cols <= i_cfg.value;
                    CFG_KERNEL: r_kern <= i_cfg.value[3:0];
                    default:    r_rows <= r_rows;
                endcase
            end
            if (i_cmd.sweep_init) begin
                r_clr <= '0;
            end else if (i_cmd.sweep_step) begin
                r_clr <= r_clr + AW'(1);
            end
            r_rd_vld <= i_cmd.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (i_cmd.decode) begin
            r_inside  <= inside_c;
            r_top     <= top_c;
            r_btm     <= btm_c;
            r_lft     <= lft_c;
            r_rgt     <= rgt_c;
            r_y       <= top_c;
            r_x       <= lft_c;
            r_cnt     <= '0;
            r_cntpass <= 1'b1;
            r_val     <= '0;
        end
        if (i_cmd.scan_step) begin
            if (r_x == r_rgt - CW'(1)) begin
                r_x <= r_lft;
                r_y <= r_y + CW'(1);
            end else begin
                r_x <= r_x + CW'(1);
            end
        end
        if (r_rd_vld && hit) begin
            r_cnt <= r_cnt + NW'(1);
        end
        if (i_cmd.byp_take) begin
            r_val <= ram_rdata;
        end
        if (i_cmd.pass_step) begin
            r_y   <= r_top;
            r_x   <= r_lft;
            r_cnt <= '0;
            if (r_cntpass) begin
                r_cntpass <= 1'b0;
                r_k       <= (r_cnt - NW'(1)) >> 1;
                r_prefix  <= '0;
                r_hmask   <= '0;
                r_bsel    <= {1'b1, {(DEPTH_BITS-1){1'b0}}};
            end else begin
                if (take_one) begin
                    r_k <= r_k - r_cnt;
                end
                r_prefix <= prefix_nx;
                r_hmask  <= r_hmask | r_bsel;
                r_bsel   <= r_bsel >> 1;
                r_val    <= prefix_nx;
            end
        end
        if (i_cmd.emit) begin
            o_out.filtered_depth <= 16'(r_val);
            o_out.out_row        <= r_item.pixel_row;
            o_out.out_col        <= r_item.pixel_col;
            o_out.coord_error    <= !r_inside;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_st.op         = r_item.opcode;
    assign o_st.sweep_last = (r_clr == AW'(DEPTH - 1));
    assign o_st.in_frame   = inside_c;
    assign o_st.kzero      = (ksat == '0);
    assign o_st.scan_last  = (r_y == r_btm - CW'(1)) && (r_x == r_rgt - CW'(1));
    assign o_st.sel_done   = r_cntpass ? (r_cnt == '0) : r_bsel[0];
    assign o_st.out_free   = !r_out_vld || i_out_ready;
endmodule
`default_nettype wire

// ===== hdl/sparse_depth_median_filter.sv =====
// Sparse depth median filter.
// Channels: i_item takes opcode, row, column and depth; o_result gives one
// item per read (opcode 2); i_cfg writes frame rows (0), frame columns (1)
// and kernel size (2). All use valid/ready; the config port is always ready
// and is to be written only while the block is idle, which the block itself
// does not enforce. Items are taken one at a time (single-port memory):
//   clear:  zeroes every frame memory entry, one entry zeroed per cycle
//   write:  stores the depth if the pixel lies inside the frame
//   read outside the frame: depth 0 with coord_error; kernel 0: stored depth
//   filtered read: median of the window clipped to the frame (up to 256
//   samples at the defaults); a window with no samples ends after the
//   counting pass with depth 0.
// The median is found by one counting pass and one pass per depth bit.
// After reset the frame memory is swept to zero, all MAX_ROWS*MAX_COLS
// entries (262144 at the defaults), with i_item held not ready.
// A result sits in an output register until taken; the next item is still
// accepted meanwhile, and its result waits while the receiver stalls.
`default_nettype none
`include "sparse_depth_median_filter_defines.svh"
module sparse_depth_median_filter import sdmf_pkg::*; #(
    parameter int MAX_ROWS   = 512,
    parameter int MAX_COLS   = 512,
    parameter int MAX_KERNEL = 15,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sdmf_in_if.sink     i_item,
    sdmf_out_if.source  o_result,
    sdmf_cfg_if.sink    i_cfg
);
    t_cmd    cmd;
    t_status st;
    logic    in_ready;

    sdmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_st       (st),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    sdmf_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_KERNEL (MAX_KERNEL),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_item      (i_item.data),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_out       (o_result.data)
    );

    assign i_item.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    `SDMF_CHECK(a_one_at_a_time, i_clk, i_rst_n, i_item.valid && i_item.ready |=> !i_item.ready)
    `SDMF_CHECK(a_sweep_blocks, i_clk, i_rst_n, cmd.sweep_step |-> !i_item.ready)
    `SDMF_CHECK(a_err_zero, i_clk, i_rst_n, o_result.valid && o_result.data.coord_error |-> o_result.data.filtered_depth == 16'd0)
    `SDMF_CHECK_ALWAYS(a_reset_idle_out, i_clk, !i_rst_n |=> !o_result.valid)
endmodule
`default_nettype wire
